// ===== rtl/core/pgat_pkg.sv =====
// shared types and constants of the page-granular allocation table
`timescale 1ns / 1ps

package pgat_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned PageW = 20;
  localparam int unsigned StatusW = 3;

  localparam int unsigned SlotCountDefault = 128;
  localparam int unsigned PageBytesDefault = 4096;

  localparam logic [AddrW-1:0] HeapBaseReset = 32'h0200_0000;
  localparam logic [PageW-1:0] PageMax = 20'hF_FFFF;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StZero     = 3'd1,
    StTooBig   = 3'd2,
    StFull     = 3'd3,
    StMapFail  = 3'd4,
    StNotFound = 3'd5
  } status_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    SIdle   = 5'b00001,
    SCheck  = 5'b00010,
    SScan   = 5'b00100,
    SUpdate = 5'b01000,
    SOut    = 5'b10000
  } state_e;

endpackage

// ===== rtl/core/page_granular_allocation_table_core.sv =====
// allocation table core: slot scan sequencer, slot memory and bump pointer
// sequence: SCheck, then the SScan slot scan (entry 0 is compared twice while the read pipeline
//   fills), then SUpdate, then SOut loads the output register
// bad size or null free skips the scan and goes from SCheck straight to SOut
// one item at a time: a new item is accepted only after the last result is loaded, set by the
//   single slot memory read port; a stalled output register holds off the next item
// reset: all slots inactive and unused (no clearing pass), bump pointer = heap base
`timescale 1ns / 1ps

module page_granular_allocation_table_core #(
  parameter int unsigned SLOT_COUNT = pgat_pkg::SlotCountDefault,
  parameter int unsigned PAGE_BYTES = pgat_pkg::PageBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [pgat_pkg::AddrW-1:0]    request_size_i,
  input  logic [pgat_pkg::AddrW-1:0]    free_address_i,
  input  logic                          pages_ok_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pgat_pkg::AddrW-1:0]    block_address_o,
  output logic [pgat_pkg::PageW-1:0]    page_count_o,
  output logic [pgat_pkg::StatusW-1:0]  status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pgat_pkg::AddrW-1:0]    cfg_data_i
);

  localparam int unsigned AddrW = pgat_pkg::AddrW;
  localparam int unsigned PageW = pgat_pkg::PageW;
  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned Shift = $clog2(PAGE_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);
  localparam logic [AddrW-1:0] SizeTop = AddrW'(33'h1_0000_0000 - 33'(PAGE_BYTES));

  pgat_pkg::state_e state_q, state_d;

  // request
  logic                 op_q, op_d;
  logic [AddrW-1:0]     arg_q, arg_d;
  logic                 ok_q, ok_d;
  logic [PageW-1:0]     pages_q, pages_d;

  // scan
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]      cmp_idx_q;
  logic [AddrW-1:0]     rd_start_q;
  logic [PageW-1:0]     rd_pages_q;
  logic                 hit_q, hit_d;
  logic [IdxW-1:0]      hit_idx_q, hit_idx_d;
  logic [AddrW-1:0]     hit_start_q, hit_start_d;
  logic [PageW-1:0]     hit_pages_q, hit_pages_d;
  logic                 empty_q, empty_d;
  logic [IdxW-1:0]      empty_idx_q, empty_idx_d;

  // table state
  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [AddrW-1:0]      bump_q, bump_d;
  logic [AddrW-1:0]      mem_start [SLOT_COUNT];
  logic [PageW-1:0]      mem_pages [SLOT_COUNT];
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [AddrW-1:0]      mem_wstart;
  logic [PageW-1:0]      mem_wpages;

  // result
  pgat_pkg::status_e     res_st_q, res_st_d;
  logic [AddrW-1:0]      res_addr_q, res_addr_d;
  logic [PageW-1:0]      res_pages_q, res_pages_d;
  pgat_pkg::status_e     out_st_q, out_st_d;
  logic [AddrW-1:0]      out_addr_q, out_addr_d;
  logic [PageW-1:0]      out_pages_q, out_pages_d;
  logic                  out_valid_q, out_valid_d;

  logic [AddrW:0]        round_sum;
  logic [AddrW:0]        pages_wide;
  logic                  too_big;
  logic                  cur_used;
  logic                  cur_active;
  logic [PageW-1:0]      cur_pages;

  assign in_ready_o = (state_q == pgat_pkg::SIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign block_address_o = out_addr_q;
  assign page_count_o = out_pages_q;
  assign status_o = out_st_q;

  assign round_sum = {1'b0, arg_q} + (AddrW+1)'(PAGE_BYTES - 1);
  assign pages_wide = round_sum >> Shift;
  assign too_big = (arg_q > SizeTop) || (pages_wide > (AddrW+1)'(pgat_pkg::PageMax));

  // a slot never written reads as zero pages
  assign cur_used = used_q[cmp_idx_q];
  assign cur_active = active_q[cmp_idx_q];
  assign cur_pages = cur_used ? rd_pages_q : '0;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    arg_d = arg_q;
    ok_d = ok_q;
    pages_d = pages_q;
    rd_idx_d = rd_idx_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_start_d = hit_start_q;
    hit_pages_d = hit_pages_q;
    empty_d = empty_q;
    empty_idx_d = empty_idx_q;
    used_d = used_q;
    active_d = active_q;
    bump_d = bump_q;
    res_st_d = res_st_q;
    res_addr_d = res_addr_q;
    res_pages_d = res_pages_q;
    out_st_d = out_st_q;
    out_addr_d = out_addr_q;
    out_pages_d = out_pages_q;
    out_valid_d = out_valid_q;
    mem_we = 1'b0;
    mem_waddr = empty_idx_q;
    mem_wstart = bump_q;
    mem_wpages = pages_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pgat_pkg::SIdle: begin
        rd_idx_d = '0;
        if (in_valid_i) begin
          op_d = operation_i;
          arg_d = (operation_i == pgat_pkg::OpFree) ? free_address_i : request_size_i;
          ok_d = pages_ok_i;
          state_d = pgat_pkg::SCheck;
        end
      end
      pgat_pkg::SCheck: begin
        pages_d = pages_wide[PageW-1:0];
        hit_d = 1'b0;
        empty_d = 1'b0;
        res_addr_d = '0;
        res_pages_d = '0;
        if (arg_q == '0) begin
          res_st_d = pgat_pkg::StZero;
          state_d = pgat_pkg::SOut;
        end else if (op_q == pgat_pkg::OpAlloc && too_big) begin
          res_st_d = pgat_pkg::StTooBig;
          state_d = pgat_pkg::SOut;
        end else begin
          state_d = pgat_pkg::SScan;
        end
      end
      pgat_pkg::SScan: begin
        if (rd_idx_q != LastIdx) begin
          rd_idx_d = rd_idx_q + IdxW'(1);
        end
        if (!hit_q) begin
          if (op_q == pgat_pkg::OpAlloc) begin
            if (!cur_active && cur_pages != '0 && cur_pages == pages_q) begin
              hit_d = 1'b1;
              hit_idx_d = cmp_idx_q;
              hit_start_d = rd_start_q;
              hit_pages_d = cur_pages;
            end
          end else if (cur_active && rd_start_q == arg_q) begin
            hit_d = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_start_d = rd_start_q;
            hit_pages_d = cur_pages;
          end
        end
        if (!empty_q && !cur_active) begin
          empty_d = 1'b1;
          empty_idx_d = cmp_idx_q;
        end
        if (cmp_idx_q == LastIdx) begin
          state_d = pgat_pkg::SUpdate;
        end
      end
      pgat_pkg::SUpdate: begin
        res_addr_d = '0;
        res_pages_d = '0;
        state_d = pgat_pkg::SOut;
        if (op_q == pgat_pkg::OpFree) begin
          if (hit_q) begin
            active_d[hit_idx_q] = 1'b0;
            res_st_d = pgat_pkg::StOk;
            res_addr_d = hit_start_q;
            res_pages_d = hit_pages_q;
          end else begin
            res_st_d = pgat_pkg::StNotFound;
          end
        end else if (hit_q) begin
          if (ok_q) begin
            active_d[hit_idx_q] = 1'b1;
            res_st_d = pgat_pkg::StOk;
            res_addr_d = hit_start_q;
            res_pages_d = hit_pages_q;
          end else begin
            res_st_d = pgat_pkg::StMapFail;
          end
        end else if (!empty_q) begin
          res_st_d = pgat_pkg::StFull;
        end else if (!ok_q) begin
          res_st_d = pgat_pkg::StMapFail;
        end else begin
          // carve fresh pages at the bump pointer
          mem_we = 1'b1;
          used_d[empty_idx_q] = 1'b1;
          active_d[empty_idx_q] = 1'b1;
          bump_d = bump_q + (AddrW'(pages_q) << Shift);
          res_st_d = pgat_pkg::StOk;
          res_addr_d = bump_q;
          res_pages_d = pages_q;
        end
      end
      pgat_pkg::SOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d = res_st_q;
          out_addr_d = res_addr_q;
          out_pages_d = res_pages_q;
          state_d = pgat_pkg::SIdle;
        end
      end
      default: begin
        state_d = pgat_pkg::SIdle;
      end
    endcase

    if (cfg_valid_i) begin
      bump_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pgat_pkg::SIdle;
      rd_idx_q <= '0;
      cmp_idx_q <= '0;
      hit_q <= 1'b0;
      empty_q <= 1'b0;
      used_q <= '0;
      active_q <= '0;
      bump_q <= pgat_pkg::HeapBaseReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_idx_q <= rd_idx_d;
      cmp_idx_q <= rd_idx_q;
      hit_q <= hit_d;
      empty_q <= empty_d;
      used_q <= used_d;
      active_q <= active_d;
      bump_q <= bump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    arg_q <= arg_d;
    ok_q <= ok_d;
    pages_q <= pages_d;
    hit_idx_q <= hit_idx_d;
    hit_start_q <= hit_start_d;
    hit_pages_q <= hit_pages_d;
    empty_idx_q <= empty_idx_d;
    res_st_q <= res_st_d;
    res_addr_q <= res_addr_d;
    res_pages_q <= res_pages_d;
    out_st_q <= out_st_d;
    out_addr_q <= out_addr_d;
    out_pages_q <= out_pages_d;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_start[mem_waddr] <= mem_wstart;
      mem_pages[mem_waddr] <= mem_wpages;
    end
    rd_start_q <= mem_start[rd_idx_q];
    rd_pages_q <= mem_pages[rd_idx_q];
  end

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pgat_pkg::StOk |-> block_address_o == '0 && page_count_o == '0)
    else $error("failed item carries nonzero address or page count");

  a_ok_pages : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pgat_pkg::StOk |-> page_count_o != '0)
    else $error("successful item with zero pages");

  a_active_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~used_q) == '0)
    else $error("active slot that was never carved");

  a_update_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pgat_pkg::SUpdate |-> $past(state_q) == pgat_pkg::SScan
      && $past(cmp_idx_q) == LastIdx)
    else $error("update without a complete scan");

  a_out_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_addr_q) && $stable(out_st_q))
    else $error("output register overwritten while waiting");

endmodule
